// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/brl_pkg.sv -----
// shared types and constants of the line rasterizer
`default_nettype none
package brl_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int COLOR_BITS = 24;
  localparam logic [COLOR_BITS-1:0] LINE_COLOR_RST = 24'hFFFFFF;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } brl_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } brl_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic last_step;
    logic out_free;
  } brl_status_t;

endpackage
`default_nettype wire

// ----- hdl/brl_ctrl.sv -----
// controller state machine of the line rasterizer
`default_nettype none
module brl_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  brl_pkg::brl_status_t status,
  output brl_pkg::brl_cmd_t    cmd
);
  import brl_pkg::*;

  brl_state_t state_r;
  brl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!status.zero_len) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/brl_datapath.sv -----
// stepping datapath and output register of the line rasterizer
`default_nettype none
module brl_datapath #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire  [brl_pkg::COLOR_BITS-1:0]  cfg_wr_data,
  input  wire  [COORD_BITS-1:0]           start_x,
  input  wire  [COORD_BITS-1:0]           start_y,
  input  wire  [COORD_BITS-1:0]           end_x,
  input  wire  [COORD_BITS-1:0]           end_y,
  input  brl_pkg::brl_cmd_t               cmd,
  output brl_pkg::brl_status_t            status,
  input  wire                             out_tready,
  output logic                            out_valid,
  output logic [COORD_BITS-1:0]           pixel_x,
  output logic [COORD_BITS-1:0]           pixel_y,
  output logic [brl_pkg::COLOR_BITS-1:0]  pixel_color,
  output logic                            last_pixel
);
  import brl_pkg::*;

  localparam int EW = COORD_BITS + 3;

  logic [COLOR_BITS-1:0] line_color_r;
  logic [COORD_BITS-1:0] cur_x_r;
  logic [COORD_BITS-1:0] cur_y_r;
  logic signed [EW-1:0]  err_r;
  logic [COORD_BITS-1:0] maj_r;
  logic [COORD_BITS-1:0] min_r;
  logic [COORD_BITS-1:0] steps_r;
  logic                  sxn_r;
  logic                  syn_r;
  logic                  swp_r;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_last_r;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  swp_in;
  logic [COORD_BITS-1:0] maj_in;
  logic [COORD_BITS-1:0] min_in;
  logic signed [EW-1:0]  err_init;
  logic                  err_ge;
  logic signed [EW-1:0]  err_a;
  logic signed [EW-1:0]  err_nxt;
  logic                  step_x;
  logic                  step_y;
  logic [COORD_BITS-1:0] x_nxt;
  logic [COORD_BITS-1:0] y_nxt;

  // segment setup
  always_comb begin
    dx = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
    dy = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    swp_in = dy > dx;
    maj_in = swp_in ? dy : dx;
    min_in = swp_in ? dx : dy;
    err_init = $signed({2'b00, min_in, 1'b0}) - $signed({3'b000, maj_in});
  end

  // one bresenham step
  always_comb begin
    err_ge = !err_r[EW-1];
    err_a = err_ge ? (err_r - $signed({2'b00, maj_r, 1'b0})) : err_r;
    err_nxt = err_a + $signed({2'b00, min_r, 1'b0});
    step_x = swp_r ? err_ge : 1'b1;
    step_y = swp_r ? 1'b1 : err_ge;
    x_nxt = step_x ? (sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
    y_nxt = step_y ? (syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_color_r <= LINE_COLOR_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_color_r <= cfg_wr_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= start_x;
      cur_y_r <= start_y;
      err_r <= err_init;
      maj_r <= maj_in;
      min_r <= min_in;
      steps_r <= maj_in;
      sxn_r <= end_x < start_x;
      syn_r <= end_y < start_y;
      swp_r <= swp_in;
    end else if (cmd.emit) begin
      cur_x_r <= x_nxt;
      cur_y_r <= y_nxt;
      err_r <= err_nxt;
      steps_r <= steps_r - 1'b1;
    end
    if (cmd.emit) begin
      out_x_r <= cur_x_r;
      out_y_r <= cur_y_r;
      out_color_r <= line_color_r;
      out_last_r <= (steps_r == COORD_BITS'(1));
    end
  end

  assign status.zero_len = (start_x == end_x) && (start_y == end_y);
  assign status.last_step = (steps_r == COORD_BITS'(1));
  assign status.out_free = !out_valid_r || out_tready;

  assign out_valid = out_valid_r;
  assign pixel_x = out_x_r;
  assign pixel_y = out_y_r;
  assign pixel_color = out_color_r;
  assign last_pixel = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/bresenham_line_rasterizer.sv -----
// top level of the bresenham line rasterizer
// a segment of n pixels occupies the input side for its setup cycle and then one pixel per
// cycle from the shared stepping unit; a zero-length segment takes only the setup cycle;
// after setup each step writes the output register; output stalls pause stepping
// synchronous active-low reset returns to idle, empties the output and sets color to white
`default_nettype none
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [brl_pkg::COLOR_BITS-1:0]     cfg_wr_data,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // start_x, start_y, end_x, end_y
  input  wire  [((4*COORD_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [((2*COORD_BITS+brl_pkg::COLOR_BITS+7)/8)*8-1:0] out_tdata,
  output logic                               out_tlast
);
  import brl_pkg::*;

  localparam int OUT_DW = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

  brl_cmd_t              cmd;
  brl_status_t           status;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  brl_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start_x     (in_tdata[COORD_BITS-1:0]),
    .start_y     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y       (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (out_tlast)
  );

  assign out_tdata = OUT_DW'({pixel_color, pixel_y, pixel_x});

endmodule
`default_nettype wire

// ----- hdl/brl_checker.sv -----
// port-level checker of the line rasterizer and its bind
`default_nettype none
`include "assert_macros.svh"
module brl_checker #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire [((4*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [((2*COORD_BITS+brl_pkg::COLOR_BITS+7)/8)*8-1:0] out_tdata,
  input wire                                out_tlast
);
  import brl_pkg::*;

  logic in_beat;
  logic seg_nonzero;

  assign in_beat = in_tvalid && in_tready;
  assign seg_nonzero =
    (in_tdata[COORD_BITS-1:0] != in_tdata[3*COORD_BITS-1:2*COORD_BITS]) ||
    (in_tdata[2*COORD_BITS-1:COORD_BITS] != in_tdata[4*COORD_BITS-1:3*COORD_BITS]);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  `ASSERT_NEXT(a_busy_after_seg, clk, rst_n, in_beat && seg_nonzero, !in_tready)
  `ASSERT_SAME(a_run_continues, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

endmodule

bind bresenham_line_rasterizer brl_checker #(
  .COORD_BITS (COORD_BITS)
) u_brl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
